// ----- rtl/psc_pkg.sv -----
`timescale 1ns / 1ps

package psc_pkg;

  localparam int CMD_W = 3;
  localparam int ID_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FOLLOW = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONC   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BEFORE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_AFTER  = 3'd5;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_TEST1   = 12'b0000_0000_0010,
    S_TEST2   = 12'b0000_0000_0100,
    S_CLR_IMP = 12'b0000_0000_1000,
    S_ADD_CLR = 12'b0000_0001_0000,
    S_ADD_P   = 12'b0000_0010_0000,
    S_ADD_F1  = 12'b0000_0100_0000,
    S_ADD_F1C = 12'b0000_1000_0000,
    S_ADD_Q   = 12'b0001_0000_0000,
    S_ADD_P2  = 12'b0010_0000_0000,
    S_ADD_P2C = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic idle;
    logic done;
    logic ok;
  } ctrl_status_t;

endpackage

// ----- rtl/psc_row_mem.sv -----
`timescale 1ns / 1ps

// Row memory, one row per step. Rows never written read as all ones.
module psc_row_mem #(
  parameter int STEPS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(STEPS)-1:0] rd_row_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(STEPS)-1:0] wr_row_i,
  input  logic [STEPS-1:0]         wr_data_i,
  output logic [STEPS-1:0]         rd_data_o
);

  logic [STEPS-1:0] mem_q [STEPS];
  logic [STEPS-1:0] row_valid_q;
  logic [STEPS-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
      rd_vld_q  <= row_valid_q[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (wr_en_i) begin
      row_valid_q[wr_row_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '1;

endmodule

// ----- rtl/psc_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer plus the shared bit test / bit clear unit.
// Every work state reads one row, then tests or clears one bit of it.
module psc_ctrl #(
  parameter int STEPS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psc_pkg::CMD_W-1:0]  cmd_i,
  input  logic [psc_pkg::ID_W-1:0]   first_id_i,
  input  logic [psc_pkg::ID_W-1:0]   second_id_i,
  input  logic                       res_ready_i,
  output psc_pkg::ctrl_status_t      status_o,
  output logic                       rd_en_o,
  output logic [$clog2(STEPS)-1:0]   rd_row_o,
  output logic                       wr_en_o,
  output logic [$clog2(STEPS)-1:0]   wr_row_o,
  output logic [STEPS-1:0]           wr_data_o,
  input  logic [STEPS-1:0]           rd_data_i
);

  localparam int RW = $clog2(STEPS);
  localparam logic [RW-1:0] LAST = RW'(STEPS - 1);

  psc_pkg::state_e state_q, state_d;
  logic                      wait_q, wait_d;
  logic [psc_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [psc_pkg::ID_W-1:0]  f_q, f_d, s_q, s_d;
  logic [RW-1:0]             i_q, i_d;
  logic                      ok_q, ok_d;

  logic [RW-1:0] row_f, row_s, row, col;
  logic          is_clear, bit_val, i_eq_a, i_eq_b, in_range, ids_eq;

  assign row_f  = RW'(f_q);
  assign row_s  = RW'(s_q);
  assign i_eq_a = (i_q == row_s);
  assign i_eq_b = (i_q == row_f);

  assign in_range = (32'(first_id_i) < 32'(STEPS)) && (32'(second_id_i) < 32'(STEPS));
  assign ids_eq   = (first_id_i == second_id_i);

  // address of the bit handled in this state
  always_comb begin
    row      = row_f;
    col      = row_s;
    is_clear = 1'b0;
    case (state_q)
      psc_pkg::S_TEST1: begin
        if (cmd_q inside {psc_pkg::CMD_FOLLOW, psc_pkg::CMD_AFTER}) begin
          row = row_s;
          col = row_f;
        end
      end
      psc_pkg::S_TEST2: begin
        row = row_s;
        col = row_f;
      end
      psc_pkg::S_CLR_IMP: begin
        is_clear = 1'b1;
        if (cmd_q == psc_pkg::CMD_BEFORE) begin
          row = row_s;
          col = row_f;
        end
      end
      psc_pkg::S_ADD_CLR: begin
        is_clear = 1'b1;
        row      = row_s;
        col      = row_f;
      end
      psc_pkg::S_ADD_P, psc_pkg::S_ADD_P2: begin
        row = i_q;
        col = row_s;
      end
      psc_pkg::S_ADD_F1, psc_pkg::S_ADD_Q: begin
        row = row_f;
        col = i_q;
      end
      psc_pkg::S_ADD_F1C: begin
        is_clear = 1'b1;
        row      = i_q;
        col      = row_f;
      end
      psc_pkg::S_ADD_P2C: begin
        is_clear = 1'b1;
        row      = row_s;
        col      = i_q;
      end
      default: ;
    endcase
  end

  // shared bit unit
  assign bit_val   = rd_data_i[col];
  assign wr_data_o = rd_data_i & ~(STEPS'(1) << col);
  assign wr_row_o  = row;
  assign rd_row_o  = row;

  assign rd_en_o = !wait_q && (state_q != psc_pkg::S_IDLE) && (state_q != psc_pkg::S_DONE);
  assign wr_en_o = wait_q && is_clear;

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    cmd_d   = cmd_q;
    f_d     = f_q;
    s_d     = s_q;
    i_d     = i_q;
    ok_d    = ok_q;
    case (state_q)
      psc_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          f_d     = first_id_i;
          s_d     = second_id_i;
          wait_d  = 1'b0;
          state_d = psc_pkg::S_DONE;
          case (cmd_i)
            psc_pkg::CMD_ADD: begin
              ok_d = 1'b0;
              if (in_range) state_d = psc_pkg::S_ADD_CLR;
            end
            psc_pkg::CMD_PREC, psc_pkg::CMD_FOLLOW: begin
              ok_d = !in_range;
              if (in_range && !ids_eq) state_d = psc_pkg::S_TEST1;
            end
            psc_pkg::CMD_CONC: begin
              ok_d = 1'b1;
              if (in_range && !ids_eq) state_d = psc_pkg::S_TEST1;
            end
            psc_pkg::CMD_BEFORE, psc_pkg::CMD_AFTER: begin
              ok_d = 1'b0;
              if (in_range && !ids_eq) state_d = psc_pkg::S_TEST1;
            end
            default: ok_d = 1'b0;
          endcase
        end
      end
      psc_pkg::S_DONE: begin
        if (res_ready_i) state_d = psc_pkg::S_IDLE;
      end
      default: begin
        if (!wait_q) begin
          wait_d = 1'b1;
        end else begin
          wait_d = 1'b0;
          case (state_q)
            psc_pkg::S_TEST1: begin
              ok_d    = bit_val;
              state_d = psc_pkg::S_DONE;
              if (bit_val) begin
                case (cmd_q)
                  psc_pkg::CMD_CONC:   state_d = psc_pkg::S_TEST2;
                  psc_pkg::CMD_BEFORE: state_d = psc_pkg::S_CLR_IMP;
                  psc_pkg::CMD_AFTER:  state_d = psc_pkg::S_CLR_IMP;
                  default:             state_d = psc_pkg::S_DONE;
                endcase
              end
            end
            psc_pkg::S_TEST2: begin
              ok_d    = bit_val;
              state_d = psc_pkg::S_DONE;
            end
            psc_pkg::S_CLR_IMP: begin
              ok_d    = 1'b1;
              state_d = psc_pkg::S_DONE;
            end
            psc_pkg::S_ADD_CLR: begin
              i_d     = '0;
              state_d = psc_pkg::S_ADD_P;
            end
            psc_pkg::S_ADD_P: begin
              // step i not able to precede a: it must come after b
              state_d = (i_eq_a || !bit_val) ? psc_pkg::S_ADD_F1 : psc_pkg::S_ADD_Q;
            end
            psc_pkg::S_ADD_F1: begin
              if (i_eq_b || !bit_val) begin
                ok_d    = 1'b0;
                state_d = psc_pkg::S_DONE;
              end else begin
                state_d = psc_pkg::S_ADD_F1C;
              end
            end
            psc_pkg::S_ADD_F1C: state_d = psc_pkg::S_ADD_Q;
            psc_pkg::S_ADD_Q: begin
              // step i not able to follow b: it must come before a
              if (i_eq_b || !bit_val) begin
                state_d = psc_pkg::S_ADD_P2;
              end else if (i_q == LAST) begin
                ok_d    = 1'b1;
                state_d = psc_pkg::S_DONE;
              end else begin
                i_d     = i_q + RW'(1);
                state_d = psc_pkg::S_ADD_P;
              end
            end
            psc_pkg::S_ADD_P2: begin
              if (i_eq_a || !bit_val) begin
                ok_d    = 1'b0;
                state_d = psc_pkg::S_DONE;
              end else begin
                state_d = psc_pkg::S_ADD_P2C;
              end
            end
            psc_pkg::S_ADD_P2C: begin
              if (i_q == LAST) begin
                ok_d    = 1'b1;
                state_d = psc_pkg::S_DONE;
              end else begin
                i_d     = i_q + RW'(1);
                state_d = psc_pkg::S_ADD_P;
              end
            end
            default: state_d = psc_pkg::S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psc_pkg::S_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    f_q   <= f_d;
    s_q   <= s_d;
    i_q   <= i_d;
    ok_q  <= ok_d;
  end

  assign status_o.idle = (state_q == psc_pkg::S_IDLE);
  assign status_o.done = (state_q == psc_pkg::S_DONE) && res_ready_i;
  assign status_o.ok   = ok_q;

endmodule

// ----- rtl/step_precedence_constraint_store_top.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+-----------------------------------
// in       | in  | in_valid_i / in_stall_o | cmd_i[2:0], first_id_i, second_id_i
// out      | out | out_valid_o/ out_stall_i| ok_o
//
// One request at a time. The answer register loads as the sequencer returns to
// idle, before the next request can be accepted. Bad-id, unused-command and
// equal-id query or impose requests go straight to done; other requests read
// a memory row, then test or write back one bit of it, per step. Add ordering
// walks every step row, ending early on a conflict. Reset marks all rows
// unwritten (all ones). A held answer under out_stall_i keeps the sequencer done.
module step_precedence_constraint_store_top #(
  parameter int STEPS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [psc_pkg::CMD_W-1:0] cmd_i,
  input  logic [psc_pkg::ID_W-1:0]  first_id_i,
  input  logic [psc_pkg::ID_W-1:0]  second_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o
);

  localparam int RW = $clog2(STEPS);

  psc_pkg::ctrl_status_t status;
  logic                  start, res_ready;
  logic                  out_valid_q, ok_q;

  logic             rd_en, wr_en;
  logic [RW-1:0]    rd_row, wr_row;
  logic [STEPS-1:0] wr_data, rd_data;

  // busy while a request is in the sequencer
  assign in_stall_o = !status.idle;
  assign start      = in_valid_i && !in_stall_o;
  assign res_ready  = !out_valid_q || !out_stall_i;

  psc_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd_i),
    .first_id_i (first_id_i),
    .second_id_i(second_id_i),
    .res_ready_i(res_ready),
    .status_o   (status),
    .rd_en_o    (rd_en),
    .rd_row_o   (rd_row),
    .wr_en_o    (wr_en),
    .wr_row_o   (wr_row),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data)
  );

  psc_row_mem #(
    .STEPS(STEPS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_row_i (rd_row),
    .wr_en_i  (wr_en),
    .wr_row_i (wr_row),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (status.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done) begin
      ok_q <= status.ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;

endmodule
